// ----- rtl/mtep_pkg.sv -----
package mtep_pkg;

  localparam int unsigned CHANNELS  = 16;
  localparam int unsigned NOTES     = 128;
  localparam int unsigned TBL_DEPTH = CHANNELS * NOTES;
  localparam int unsigned TBL_AW    = $clog2(TBL_DEPTH);
  localparam int unsigned DIDX_W    = TBL_AW + 1;
  localparam int unsigned NOTE_W    = $clog2(NOTES);

  localparam logic [7:0]  META_TEMPO    = 8'h51;
  localparam logic [7:0]  META_EOT      = 8'h2F;
  localparam logic [7:0]  ST_SYSEX      = 8'hF0;
  localparam logic [7:0]  ST_ESCAPE     = 8'hF7;
  localparam logic [7:0]  ST_META       = 8'hFF;
  localparam logic [23:0] TEMPO_DEFAULT = 24'd500000;
  localparam logic [7:0]  NUM_BEND      = 8'd128;
  localparam logic [7:0]  NUM_PRESSURE  = 8'd129;

  localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
  localparam logic [3:0] HI_NOTE_ON   = 4'h9;
  localparam logic [3:0] HI_CTRL      = 4'hB;
  localparam logic [3:0] HI_PROGRAM   = 4'hC;
  localparam logic [3:0] HI_PRESSURE  = 4'hD;
  localparam logic [3:0] HI_BEND      = 4'hE;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_END   = 2'd1,
    OP_DRAIN = 2'd2,
    OP_START = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    K_NOTE    = 3'd0,
    K_TEMPO   = 3'd1,
    K_CTRL    = 3'd2,
    K_END     = 3'd3,
    K_DRAINED = 3'd4,
    K_ERROR   = 3'd5
  } kind_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] tick;
    logic [30:0] start_tick;
    logic [3:0]  channel;
    logic [7:0]  number;
    logic [6:0]  value;
    logic [23:0] tempo_us;
  } res_t;

  typedef struct packed {
    logic        vld;
    logic [30:0] on_tick;
    logic [6:0]  vel;
  } held_t;

endpackage

// ----- rtl/mtep_front.sv -----
module mtep_front import mtep_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] in_cmd_i,
  input  logic [7:0] in_byte_i,
  output logic       q_valid_o,
  output item_t      q_item_o,
  input  logic       q_pop_i
);

  // two-entry request queue
  item_t      slot_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  item_t      itm;

  always_comb begin
    itm.op   = op_e'(in_cmd_i);
    itm.data = in_byte_i;
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = slot_q[rp_q];
  assign push       = in_valid_i & in_ready_o;
  assign pop        = q_pop_i & q_valid_o;

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wp_q] <= itm;
    end
  end

endmodule

// ----- rtl/mtep_back.sv -----
module mtep_back import mtep_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  q_valid_i,
  input  item_t q_item_i,
  output logic  q_pop_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output res_t  out_res_o
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_NOTE  = 4'b0100,
    S_DRAIN = 4'b1000
  } state_e;

  typedef enum logic [10:0] {
    PH_DELTA     = 11'b000_0000_0001,
    PH_STATUS    = 11'b000_0000_0010,
    PH_DATA1     = 11'b000_0000_0100,
    PH_DATA2     = 11'b000_0000_1000,
    PH_META_TYPE = 11'b000_0001_0000,
    PH_META_LEN  = 11'b000_0010_0000,
    PH_SYSEX_LEN = 11'b000_0100_0000,
    PH_TEMPO     = 11'b000_1000_0000,
    PH_SKIP      = 11'b001_0000_0000,
    PH_SKIP_EOT  = 11'b010_0000_0000,
    PH_ENDED     = 11'b100_0000_0000
  } phase_e;

  state_e            st_q, st_d;
  phase_e            ph_q, ph_d;
  logic [7:0]        rs_q, rs_d;
  logic [31:0]       tick_q, tick_d;
  logic [27:0]       len_q, len_d;
  logic [2:0]        lcnt_q, lcnt_d;
  logic [27:0]       skip_q, skip_d;
  logic [7:0]        meta_q, meta_d;
  logic [6:0]        fd_q, fd_d;
  logic [23:0]       tempo_q, tempo_d;
  logic              halt_q, halt_d;
  logic [DIDX_W-1:0] didx_q, didx_d;
  logic [DIDX_W-1:0] clr_q, clr_d;
  logic              ovld_q, ovld_d;
  res_t              ores_q, ores_d;

  held_t             mem [TBL_DEPTH];
  held_t             rd_q;
  logic              mem_we;
  logic [TBL_AW-1:0] mem_addr;
  held_t             mem_wd;

  logic              out_free, take, emit;
  res_t              res;
  logic [7:0]        b;
  logic [27:0]       nlen;
  logic [2:0]        ncnt;
  logic              lb_done, lb_long;
  logic [3:0]        hi, ch;
  logic [TBL_AW-1:0] note_addr;
  logic [DIDX_W-1:0] didx_nx;
  logic [23:0]       ntempo;
  logic [2:0]        ntcnt;

  assign out_free  = !ovld_q || out_ready_i;
  assign take      = (st_q == S_IDLE) && q_valid_i && out_free;
  assign q_pop_o   = take;
  assign b         = q_item_i.data;
  assign nlen      = {len_q[20:0], b[6:0]};
  assign ncnt      = lcnt_q + 3'd1;
  assign lb_done   = !b[7];
  assign lb_long   = b[7] && (ncnt >= 3'd4);
  assign hi        = rs_q[7:4];
  assign ch        = rs_q[3:0];
  assign note_addr = TBL_AW'({ch, fd_q});
  assign didx_nx   = didx_q + DIDX_W'(1);
  assign ntempo    = {tempo_q[15:0], b};
  assign ntcnt     = lcnt_q + 3'd1;

  always_comb begin
    st_d     = st_q;
    ph_d     = ph_q;
    rs_d     = rs_q;
    tick_d   = tick_q;
    len_d    = len_q;
    lcnt_d   = lcnt_q;
    skip_d   = skip_q;
    meta_d   = meta_q;
    fd_d     = fd_q;
    tempo_d  = tempo_q;
    halt_d   = halt_q;
    didx_d   = didx_q;
    clr_d    = clr_q;
    mem_we   = 1'b0;
    mem_addr = TBL_AW'(didx_q);
    mem_wd   = '0;
    emit     = 1'b0;
    res      = '0;
    res.tick = tick_q;

    case (st_q)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = TBL_AW'(clr_q);
        clr_d    = clr_q + DIDX_W'(1);
        if (clr_q == DIDX_W'(TBL_DEPTH - 1)) begin
          st_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (take) begin
          if (q_item_i.op == OP_START) begin
            ph_d    = PH_DELTA;
            rs_d    = '0;
            tick_d  = '0;
            len_d   = '0;
            lcnt_d  = '0;
            skip_d  = '0;
            meta_d  = '0;
            fd_d    = '0;
            tempo_d = '0;
            halt_d  = 1'b0;
            didx_d  = '0;
            clr_d   = '0;
            st_d    = S_CLEAR;
          end else if (!halt_q) begin
            case (q_item_i.op)
              OP_BYTE: begin
                case (ph_q)
                  PH_DELTA: begin
                    len_d  = nlen;
                    lcnt_d = ncnt;
                    if (lb_long) begin
                      halt_d   = 1'b1;
                      emit     = 1'b1;
                      res.kind = K_ERROR;
                    end else if (lb_done) begin
                      tick_d = tick_q + 32'(nlen);
                      ph_d   = PH_STATUS;
                    end
                  end
                  PH_STATUS, PH_DATA1: begin
                    if (ph_q == PH_STATUS && b >= 8'h80) begin
                      if (b < ST_SYSEX) begin
                        rs_d = b;
                        ph_d = PH_DATA1;
                      end else begin
                        rs_d = '0;
                        if (b == ST_META) begin
                          ph_d = PH_META_TYPE;
                        end else if (b == ST_SYSEX || b == ST_ESCAPE) begin
                          len_d  = '0;
                          lcnt_d = '0;
                          ph_d   = PH_SYSEX_LEN;
                        end else begin
                          halt_d   = 1'b1;
                          emit     = 1'b1;
                          res.kind = K_ERROR;
                        end
                      end
                    end else if (ph_q == PH_STATUS && rs_q == 8'd0) begin
                      // data byte with no running status
                      halt_d   = 1'b1;
                      emit     = 1'b1;
                      res.kind = K_ERROR;
                    end else begin
                      fd_d = b[6:0];
                      if (hi == HI_PRESSURE) begin
                        len_d       = '0;
                        lcnt_d      = '0;
                        ph_d        = PH_DELTA;
                        emit        = 1'b1;
                        res.kind    = K_CTRL;
                        res.channel = ch;
                        res.number  = NUM_PRESSURE;
                        res.value   = b[6:0];
                      end else if (hi == HI_PROGRAM) begin
                        len_d  = '0;
                        lcnt_d = '0;
                        ph_d   = PH_DELTA;
                      end else begin
                        ph_d = PH_DATA2;
                      end
                    end
                  end
                  PH_DATA2: begin
                    len_d  = '0;
                    lcnt_d = '0;
                    ph_d   = PH_DELTA;
                    if (hi == HI_NOTE_OFF || hi == HI_NOTE_ON) begin
                      if (5'(ch) < 5'(CHANNELS)) begin
                        mem_addr = note_addr;
                        if (hi == HI_NOTE_OFF || b[6:0] == 7'd0) begin
                          st_d = S_NOTE;  // read held entry, decide next cycle
                        end else begin
                          mem_we         = 1'b1;
                          mem_wd.vld     = 1'b1;
                          mem_wd.on_tick = tick_q[30:0];
                          mem_wd.vel     = b[6:0];
                        end
                      end
                    end else if (hi == HI_CTRL) begin
                      emit        = 1'b1;
                      res.kind    = K_CTRL;
                      res.channel = ch;
                      res.number  = {1'b0, fd_q};
                      res.value   = b[6:0];
                    end else if (hi == HI_BEND) begin
                      emit        = 1'b1;
                      res.kind    = K_CTRL;
                      res.channel = ch;
                      res.number  = NUM_BEND;
                      res.value   = b[6:0];
                    end
                  end
                  PH_META_TYPE: begin
                    meta_d = b;
                    len_d  = '0;
                    lcnt_d = '0;
                    ph_d   = PH_META_LEN;
                  end
                  PH_META_LEN, PH_SYSEX_LEN: begin
                    len_d  = nlen;
                    lcnt_d = ncnt;
                    if (lb_long) begin
                      halt_d   = 1'b1;
                      emit     = 1'b1;
                      res.kind = K_ERROR;
                    end else if (lb_done) begin
                      if (ph_q == PH_META_LEN && meta_q == META_TEMPO &&
                          nlen >= 28'd3) begin
                        skip_d  = nlen - 28'd3;
                        tempo_d = '0;
                        lcnt_d  = '0;
                        ph_d    = PH_TEMPO;
                      end else begin
                        skip_d = nlen;
                        if (ph_q == PH_META_LEN && meta_q == META_EOT) begin
                          if (nlen == 28'd0) begin
                            ph_d     = PH_ENDED;
                            didx_d   = '0;
                            emit     = 1'b1;
                            res.kind = K_END;
                          end else begin
                            ph_d = PH_SKIP_EOT;
                          end
                        end else if (nlen == 28'd0) begin
                          len_d  = '0;
                          lcnt_d = '0;
                          ph_d   = PH_DELTA;
                        end else begin
                          ph_d = PH_SKIP;
                        end
                      end
                    end
                  end
                  PH_TEMPO: begin
                    tempo_d = ntempo;
                    lcnt_d  = ntcnt;
                    if (ntcnt >= 3'd3) begin
                      if (skip_q == 28'd0) begin
                        len_d  = '0;
                        lcnt_d = '0;
                        ph_d   = PH_DELTA;
                      end else begin
                        ph_d = PH_SKIP;
                      end
                      emit         = 1'b1;
                      res.kind     = K_TEMPO;
                      res.tempo_us = (ntempo == 24'd0) ? TEMPO_DEFAULT : ntempo;
                    end
                  end
                  PH_SKIP, PH_SKIP_EOT: begin
                    skip_d = skip_q - 28'd1;
                    if (skip_q == 28'd1) begin
                      if (ph_q == PH_SKIP_EOT) begin
                        ph_d     = PH_ENDED;
                        didx_d   = '0;
                        emit     = 1'b1;
                        res.kind = K_END;
                      end else begin
                        len_d  = '0;
                        lcnt_d = '0;
                        ph_d   = PH_DELTA;
                      end
                    end
                  end
                  default: begin
                  end
                endcase
              end
              OP_END: begin
                if (ph_q != PH_ENDED) begin
                  emit = 1'b1;
                  if ((ph_q == PH_DELTA && lcnt_q == 3'd0) || ph_q == PH_STATUS) begin
                    ph_d     = PH_ENDED;
                    didx_d   = '0;
                    res.kind = K_END;
                  end else begin
                    halt_d   = 1'b1;
                    res.kind = K_ERROR;
                  end
                end
              end
              OP_DRAIN: begin
                if (ph_q == PH_ENDED) begin
                  if (didx_q == DIDX_W'(TBL_DEPTH)) begin
                    emit     = 1'b1;
                    res.kind = K_DRAINED;
                  end else begin
                    mem_addr = TBL_AW'(didx_q);
                    st_d     = S_DRAIN;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
      end

      S_NOTE: begin
        st_d = S_IDLE;
        if (rd_q.vld) begin
          mem_we         = 1'b1;
          mem_addr       = note_addr;
          emit           = 1'b1;
          res.kind       = K_NOTE;
          res.start_tick = rd_q.on_tick;
          res.channel    = ch;
          res.number     = {1'b0, fd_q};
          res.value      = rd_q.vel;
        end
      end

      S_DRAIN: begin
        // one table entry per cycle
        didx_d = didx_nx;
        if (rd_q.vld) begin
          mem_we         = 1'b1;
          mem_addr       = TBL_AW'(didx_q);
          emit           = 1'b1;
          res.kind       = K_NOTE;
          res.start_tick = rd_q.on_tick;
          res.channel    = 4'(didx_q >> NOTE_W);
          res.number     = {1'b0, didx_q[NOTE_W-1:0]};
          res.value      = rd_q.vel;
          st_d           = S_IDLE;
        end else if (didx_nx == DIDX_W'(TBL_DEPTH)) begin
          emit     = 1'b1;
          res.kind = K_DRAINED;
          st_d     = S_IDLE;
        end else begin
          mem_addr = TBL_AW'(didx_nx);
        end
      end

      default: begin
        st_d = S_IDLE;
      end
    endcase

    ovld_d = ovld_q;
    ores_d = ores_q;
    if (emit) begin
      ovld_d = 1'b1;
      ores_d = res;
    end else if (out_ready_i) begin
      ovld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_CLEAR;
      ph_q    <= PH_DELTA;
      rs_q    <= '0;
      tick_q  <= '0;
      len_q   <= '0;
      lcnt_q  <= '0;
      skip_q  <= '0;
      meta_q  <= '0;
      fd_q    <= '0;
      tempo_q <= '0;
      halt_q  <= 1'b0;
      didx_q  <= '0;
      clr_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      st_q    <= st_d;
      ph_q    <= ph_d;
      rs_q    <= rs_d;
      tick_q  <= tick_d;
      len_q   <= len_d;
      lcnt_q  <= lcnt_d;
      skip_q  <= skip_d;
      meta_q  <= meta_d;
      fd_q    <= fd_d;
      tempo_q <= tempo_d;
      halt_q  <= halt_d;
      didx_q  <= didx_d;
      clr_q   <= clr_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ores_q <= ores_d;
  end

  // held-note table, one port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end else begin
      rd_q <= mem[mem_addr];
    end
  end

  assign out_valid_o = ovld_q;
  assign out_res_o   = ores_q;

endmodule

// ----- rtl/midi_track_event_parser.sv -----
// Throughput: one request per cycle for most bytes while the output is free;
//   a note-off holds the next (table read then write), and a drain step scans
//   the held-note table one entry a cycle. Reset (rst_ni low, async) and a
//   start-new-track request run a clearing pass over the held-note table,
//   during which no request is taken.
module midi_track_event_parser import mtep_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0]   s_axis_tuser_i,   // [1:0] cmd
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [31:0] tick, [62:32] start_tick, [66:63] channel, [74:67] number,
  // [81:75] value, [105:82] tempo_us, [111:106] zero
  output logic [111:0] m_axis_tdata_o,
  output logic [2:0]   m_axis_tuser_o    // [2:0] kind
);

  logic  q_valid, q_pop;
  item_t q_item;
  res_t  res;

  mtep_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_cmd_i   (s_axis_tuser_i),
    .in_byte_i  (s_axis_tdata_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  mtep_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res)
  );

  assign m_axis_tuser_o = res.kind;
  assign m_axis_tdata_o = {6'd0, res.tempo_us, res.value, res.number, res.channel,
                           res.start_tick, res.tick};

endmodule

// ----- dv/tb_midi_track_event_parser.sv -----
module tb_midi_track_event_parser;
  import mtep_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam int unsigned RANDOM_REQS = 1950;

  typedef enum logic [3:0] {
    PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_META_TYPE, PH_META_LEN,
    PH_SYSEX_LEN, PH_TEMPO, PH_SKIP, PH_SKIP_EOT, PH_ENDED
  } parse_phase_e;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i;   // [7:0] data_byte
  logic [1:0]   s_axis_tuser_i;   // [1:0] cmd
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  // [31:0] tick, [62:32] start_tick, [66:63] channel, [74:67] number,
  // [81:75] value, [105:82] tempo_us, [111:106] zero
  logic [111:0] m_axis_tdata_o;
  logic [2:0]   m_axis_tuser_o;   // [2:0] kind

  midi_track_event_parser u_top (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o
  );

  // ---------------------------------------------------------------- predictor
  parse_phase_e parse_ph;
  logic [7:0]   run_status;
  logic [31:0]  cur_tick;
  logic [27:0]  len_acc;
  int unsigned  len_cnt;
  logic [31:0]  skip_left;
  logic [7:0]   meta_code;
  logic [6:0]   first_byte;
  logic [23:0]  tempo_acc;
  bit           halted;
  bit           held_vld [TBL_DEPTH];
  logic [30:0]  held_tick [TBL_DEPTH];
  logic [6:0]   held_vel [TBL_DEPTH];
  int unsigned  drain_idx;

  res_t         expected_events[$];

  int unsigned  fail_cnt;
  int unsigned  req_cnt;
  int unsigned  kind_seen [6];
  int unsigned  cycle_cnt;

  function automatic void push_event(kind_e k, logic [31:0] t, logic [30:0] st,
                                     logic [3:0] ch, logic [7:0] num,
                                     logic [6:0] val, logic [23:0] tmp);
    res_t r;
    r.kind       = k;
    r.tick       = t;
    r.start_tick = st;
    r.channel    = ch;
    r.number     = num;
    r.value      = val;
    r.tempo_us   = tmp;
    expected_events.insert(expected_events.size(), r);
  endfunction

  function automatic void clear_track();
    parse_ph   = PH_DELTA;
    run_status = '0;
    cur_tick   = '0;
    len_acc    = '0;
    len_cnt    = 0;
    skip_left  = '0;
    meta_code  = '0;
    first_byte = '0;
    tempo_acc  = '0;
    halted     = 1'b0;
    drain_idx  = 0;
    foreach (held_vld[i]) held_vld[i] = 1'b0;
  endfunction

  function automatic void raise_error();
    halted = 1'b1;
    push_event(K_ERROR, cur_tick, '0, '0, '0, '0, '0);
  endfunction

  function automatic void begin_length(parse_phase_e p);
    len_acc  = '0;
    len_cnt  = 0;
    parse_ph = p;
  endfunction

  // 0 more bytes, 1 complete, 2 too long
  function automatic int vlq_byte(logic [7:0] b);
    len_acc = {len_acc[20:0], b[6:0]};
    len_cnt++;
    if (!b[7]) return 1;
    if (len_cnt >= 4) return 2;
    return 0;
  endfunction

  function automatic void end_track();
    parse_ph  = PH_ENDED;
    drain_idx = 0;
    push_event(K_END, cur_tick, '0, '0, '0, '0, '0);
  endfunction

  function automatic void first_data_byte(logic [7:0] b);
    first_byte = b[6:0];
    if (run_status[7:4] == HI_PRESSURE) begin
      begin_length(PH_DELTA);
      push_event(K_CTRL, cur_tick, '0, run_status[3:0], NUM_PRESSURE, first_byte, '0);
    end else if (run_status[7:4] == HI_PROGRAM) begin
      begin_length(PH_DELTA);
    end else begin
      parse_ph = PH_DATA2;
    end
  endfunction

  function automatic void second_data_byte(logic [7:0] b);
    logic [3:0]        hi;
    logic [3:0]        ch;
    logic [TBL_AW-1:0] k;
    hi = run_status[7:4];
    ch = run_status[3:0];
    k  = {ch, first_byte};
    begin_length(PH_DELTA);
    if (hi == HI_NOTE_OFF || hi == HI_NOTE_ON) begin
      if (ch < CHANNELS) begin
        if (hi == HI_NOTE_OFF || b[6:0] == 7'd0) begin
          if (held_vld[k]) begin
            held_vld[k] = 1'b0;
            push_event(K_NOTE, cur_tick, held_tick[k], ch, {1'b0, first_byte},
                       held_vel[k], '0);
          end
        end else begin
          held_vld[k]  = 1'b1;
          held_tick[k] = cur_tick[30:0];
          held_vel[k]  = b[6:0];
        end
      end
    end else if (hi == HI_CTRL) begin
      push_event(K_CTRL, cur_tick, '0, ch, {1'b0, first_byte}, b[6:0], '0);
    end else if (hi == HI_BEND) begin
      push_event(K_CTRL, cur_tick, '0, ch, NUM_BEND, b[6:0], '0);
    end
  endfunction

  function automatic void status_position(logic [7:0] b);
    if (!b[7]) begin
      if (run_status == '0) raise_error();
      else first_data_byte(b);
    end else if (b < ST_SYSEX) begin
      run_status = b;
      parse_ph   = PH_DATA1;
    end else begin
      run_status = '0;
      if (b == ST_META) parse_ph = PH_META_TYPE;
      else if (b == ST_SYSEX || b == ST_ESCAPE) begin_length(PH_SYSEX_LEN);
      else raise_error();
    end
  endfunction

  function automatic void after_skip_length();
    if (skip_left == '0) begin_length(PH_DELTA);
    else parse_ph = PH_SKIP;
  endfunction

  function automatic void track_byte(logic [7:0] b);
    int r;
    case (parse_ph)
      PH_DELTA: begin
        r = vlq_byte(b);
        if (r == 2) raise_error();
        else if (r == 1) begin
          cur_tick = cur_tick + 32'(len_acc);
          parse_ph = PH_STATUS;
        end
      end
      PH_STATUS: status_position(b);
      PH_DATA1:  first_data_byte(b);
      PH_DATA2:  second_data_byte(b);
      PH_META_TYPE: begin
        meta_code = b;
        begin_length(PH_META_LEN);
      end
      PH_META_LEN: begin
        r = vlq_byte(b);
        if (r == 2) raise_error();
        else if (r == 1) begin
          if (meta_code == META_TEMPO && len_acc >= 3) begin
            skip_left = 32'(len_acc) - 32'd3;
            tempo_acc = '0;
            len_cnt   = 0;
            parse_ph  = PH_TEMPO;
          end else begin
            skip_left = 32'(len_acc);
            if (meta_code == META_EOT) begin
              if (skip_left == '0) end_track();
              else parse_ph = PH_SKIP_EOT;
            end else begin
              after_skip_length();
            end
          end
        end
      end
      PH_SYSEX_LEN: begin
        r = vlq_byte(b);
        if (r == 2) raise_error();
        else if (r == 1) begin
          skip_left = 32'(len_acc);
          after_skip_length();
        end
      end
      PH_TEMPO: begin
        tempo_acc = {tempo_acc[15:0], b};
        len_cnt++;
        if (len_cnt >= 3) begin
          after_skip_length();
          push_event(K_TEMPO, cur_tick, '0, '0, '0, '0,
                     (tempo_acc == '0) ? TEMPO_DEFAULT : tempo_acc);
        end
      end
      PH_SKIP: begin
        skip_left--;
        if (skip_left == '0) begin_length(PH_DELTA);
      end
      PH_SKIP_EOT: begin
        skip_left--;
        if (skip_left == '0) end_track();
      end
      default: ;
    endcase
  endfunction

  function automatic void drain_one();
    int unsigned k;
    while (drain_idx < TBL_DEPTH) begin
      k = drain_idx;
      drain_idx++;
      if (held_vld[k]) begin
        held_vld[k] = 1'b0;
        push_event(K_NOTE, cur_tick, held_tick[k], 4'(k / NOTES), 8'(k % NOTES),
                   held_vel[k], '0);
        return;
      end
    end
    push_event(K_DRAINED, cur_tick, '0, '0, '0, '0, '0);
  endfunction

  function automatic void predict_track_event(op_e op, logic [7:0] b);
    if (op == OP_START) clear_track();
    else if (!halted) begin
      case (op)
        OP_BYTE: track_byte(b);
        OP_END: begin
          if (parse_ph != PH_ENDED) begin
            if ((parse_ph == PH_DELTA && len_cnt == 0) || parse_ph == PH_STATUS)
              end_track();
            else
              raise_error();
          end
        end
        default: if (parse_ph == PH_ENDED) drain_one();
      endcase
    end
  endfunction

  // ---------------------------------------------------------------- clock, reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, expected_events.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- receiver
  bit          hold_req;
  bit          hold_done;
  int unsigned hold_left;
  int unsigned mode_left;
  int unsigned rx_mode;

  initial m_axis_tready_i = 1'b0;

  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      mode_left = $urandom_range(16, 96);
      rx_mode   = $urandom_range(0, 3);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      case (rx_mode)
        0:       m_axis_tready_i <= 1'b1;
        1:       m_axis_tready_i <= ($urandom_range(0, 1) == 0);
        2:       m_axis_tready_i <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------- result check
  always @(posedge clk_i) begin
    res_t exp_ev;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_events.size() == 0) begin
        $error("unexpected result: kind %0d tick %0d", m_axis_tuser_o,
               m_axis_tdata_o[31:0]);
        fail_cnt++;
      end else begin
        exp_ev = expected_events.pop_front();
        if (m_axis_tuser_o < 6) kind_seen[m_axis_tuser_o]++;
        if (m_axis_tuser_o != exp_ev.kind) begin
          $error("kind: expected %0d actual %0d", exp_ev.kind, m_axis_tuser_o);
          fail_cnt++;
        end
        if (m_axis_tdata_o[31:0] != exp_ev.tick) begin
          $error("tick: expected %0d actual %0d", exp_ev.tick, m_axis_tdata_o[31:0]);
          fail_cnt++;
        end
        if (m_axis_tdata_o[62:32] != exp_ev.start_tick) begin
          $error("start_tick: expected %0d actual %0d", exp_ev.start_tick,
                 m_axis_tdata_o[62:32]);
          fail_cnt++;
        end
        if (m_axis_tdata_o[66:63] != exp_ev.channel) begin
          $error("channel: expected %0d actual %0d", exp_ev.channel,
                 m_axis_tdata_o[66:63]);
          fail_cnt++;
        end
        if (m_axis_tdata_o[74:67] != exp_ev.number) begin
          $error("number: expected %0d actual %0d", exp_ev.number,
                 m_axis_tdata_o[74:67]);
          fail_cnt++;
        end
        if (m_axis_tdata_o[81:75] != exp_ev.value) begin
          $error("value: expected %0d actual %0d", exp_ev.value,
                 m_axis_tdata_o[81:75]);
          fail_cnt++;
        end
        if (m_axis_tdata_o[105:82] != exp_ev.tempo_us) begin
          $error("tempo_us: expected %0d actual %0d", exp_ev.tempo_us,
                 m_axis_tdata_o[105:82]);
          fail_cnt++;
        end
        if (m_axis_tdata_o[111:106] != '0) begin
          $error("pad: expected 0 actual %0d", m_axis_tdata_o[111:106]);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sender
  bit          idle_en;
  int unsigned burst_left;

  initial begin
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
  end

  task automatic send_request(op_e op, logic [7:0] b);
    int unsigned gap;
    @(negedge clk_i);
    if (idle_en && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_track_event(op, b);
    req_cnt++;
  endtask

  task automatic send_vlq(logic [27:0] v, int unsigned pad);
    logic [7:0]  grp [4];
    int unsigned n;
    n = 1;
    for (int i = 0; i < 4; i++) grp[i] = {1'b0, v[7*i +: 7]};
    for (int i = 1; i < 4; i++) if (grp[i] != '0) n = i + 1;
    if (n + pad > 4) pad = 4 - n;
    n = n + pad;
    for (int i = n - 1; i >= 0; i--)
      send_request(OP_BYTE, (i == 0) ? grp[0] : (grp[i] | 8'h80));
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    idle_en = 1'b0;
    send_request(OP_DRAIN, 8'h00);       // drain before track end: ignored
    send_request(OP_BYTE, 8'h00);
    send_request(OP_BYTE, 8'h45);        // no running status yet
    send_request(OP_BYTE, 8'hFF);        // halted: ignored
    send_request(OP_START, 8'h00);
    send_request(OP_BYTE, 8'h00);
    send_request(OP_BYTE, 8'h9F);
    send_request(OP_BYTE, 8'h7F);
    send_request(OP_BYTE, 8'h7F);
    send_vlq(28'h0FF_FFFF, 0);
    send_request(OP_BYTE, 8'h7F);        // running status, velocity zero
    send_request(OP_BYTE, 8'h00);
    send_request(OP_BYTE, 8'h00);
    send_request(OP_BYTE, 8'hFF);
    send_request(OP_BYTE, META_TEMPO);
    send_request(OP_BYTE, 8'h03);
    repeat (3) send_request(OP_BYTE, 8'h00);   // zero tempo maps to default
    send_request(OP_BYTE, 8'h00);
    send_request(OP_BYTE, 8'hF1);        // undefined system status
    send_request(OP_START, 8'h00);
    send_request(OP_END, 8'h00);         // clean end on an empty track
    send_request(OP_END, 8'h00);
    send_request(OP_DRAIN, 8'h00);
  endtask

  task automatic send_event(ref logic [7:0] last_st);
    int unsigned r;
    int unsigned n;
    logic [7:0]  st;
    logic [6:0]  note;
    r    = $urandom_range(0, 99);
    note = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 7)) : 7'($urandom);
    if (r < 55) begin
      if (r < 30)      st = {HI_NOTE_ON, 4'($urandom)};
      else if (r < 40) st = {HI_NOTE_OFF, 4'($urandom)};
      else if (r < 45) st = {HI_CTRL, 4'($urandom)};
      else if (r < 48) st = {HI_BEND, 4'($urandom)};
      else if (r < 51) st = {HI_PRESSURE, 4'($urandom)};
      else if (r < 53) st = {HI_PROGRAM, 4'($urandom)};
      else             st = {4'hA, 4'($urandom)};
      // keep channels few so that note-offs find their note-ons
      if (st[7:4] == HI_NOTE_ON || st[7:4] == HI_NOTE_OFF) st[3:2] = 2'b00;
      if (st != last_st || $urandom_range(0, 1) == 0) send_request(OP_BYTE, st);
      last_st = st;
      send_request(OP_BYTE, {1'b0, note});
      if (st[7:4] != HI_PROGRAM && st[7:4] != HI_PRESSURE)
        send_request(OP_BYTE, ($urandom_range(0, 4) == 0) ? 8'h00 : {1'b0, 7'($urandom)});
    end else if (r < 88) begin
      last_st = '0;
      if (r < 68) begin
        send_request(OP_BYTE, ST_META);
        send_request(OP_BYTE, META_TEMPO);
        n = $urandom_range(0, 5);
        send_vlq(28'(n), $urandom_range(0, 1));
      end else if (r < 78) begin
        send_request(OP_BYTE, ST_META);
        send_request(OP_BYTE, 8'($urandom_range(0, 127)) ^ 8'h2A);
        n = $urandom_range(0, 4);
        send_vlq(28'(n), $urandom_range(0, 2));
      end else begin
        send_request(OP_BYTE, ($urandom_range(0, 1) == 0) ? ST_SYSEX : ST_ESCAPE);
        n = $urandom_range(0, 5);
        send_vlq(28'(n), $urandom_range(0, 1));
      end
      for (int i = 0; i < n; i++)
        send_request(OP_BYTE, ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
    end else begin
      // noise and broken sequences
      r = $urandom_range(0, 4);
      if (r == 0)      send_request(OP_BYTE, 8'($urandom));
      else if (r == 1) send_request(op_e'($urandom_range(1, 2)), 8'($urandom));
      else if (r == 2) send_request(OP_BYTE, 8'($urandom_range(8'hF1, 8'hFE)));
      else if (r == 3) send_request(OP_BYTE, 8'($urandom_range(0, 127)));
      else             repeat (5) send_request(OP_BYTE, 8'h80 | 8'($urandom));
    end
  endtask

  task automatic send_track(bit wide_deltas);
    int unsigned n_ev;
    int unsigned r;
    logic [7:0]  last_st;
    logic [27:0] dt;
    last_st = '0;
    send_request(OP_START, 8'($urandom));
    n_ev = $urandom_range(4, 40);
    for (int e = 0; e < n_ev; e++) begin
      if (wide_deltas)
        dt = 28'h0FF_FFFF - 28'($urandom_range(0, 255));
      else if ($urandom_range(0, 3) == 0)
        dt = 28'($urandom);
      else
        dt = 28'($urandom_range(0, 200));
      send_vlq(dt, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0);
      send_event(last_st);
    end
    send_vlq(28'($urandom_range(0, 20)), 0);
    r = $urandom_range(0, 9);
    if (r < 5) begin
      send_request(OP_BYTE, ST_META);
      send_request(OP_BYTE, META_EOT);
      r = $urandom_range(0, 2);
      send_vlq(28'(r), 0);
      repeat (r) send_request(OP_BYTE, 8'($urandom));
    end else if (r < 8) begin
      send_request(OP_END, 8'($urandom));
    end else if (r == 8) begin
      send_request(OP_BYTE, 8'h90);
      send_request(OP_END, 8'($urandom));          // truncated event
    end else begin
      repeat (5) send_request(OP_BYTE, 8'hFF);     // five-byte delta
    end
    if ($urandom_range(0, 1) == 0) begin
      send_request(OP_BYTE, 8'($urandom));
      send_request(OP_END, 8'h00);
    end
    repeat ($urandom_range(2, 30)) send_request(OP_DRAIN, 8'($urandom));
  endtask

  task automatic test_random_tracks();
    int unsigned base;
    int unsigned trk;
    base    = req_cnt;
    idle_en = 1'b1;
    trk     = 0;
    while (req_cnt - base < RANDOM_REQS) begin
      idle_en = (trk % 5 != 2);
      if (trk == 3) hold_req = 1'b1;   // long receiver stall, sender keeps going
      send_track(trk % 4 == 1);
      trk++;
    end
  endtask

  initial begin
    clear_track();
    wait (rst_ni);
    test_directed();
    test_random_tracks();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    wait (expected_events.size() == 0);
    repeat (50) @(posedge clk_i);
    $display("Covered %0d requests: notes %0d, tempo %0d, controllers %0d,",
             req_cnt, kind_seen[K_NOTE], kind_seen[K_TEMPO], kind_seen[K_CTRL]);
    $display("  track ends %0d, drain done %0d, errors %0d, in %0d cycles",
             kind_seen[K_END], kind_seen[K_DRAINED], kind_seen[K_ERROR], cycle_cnt);
    if (fail_cnt == 0 && expected_events.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
